/* design/bir_pkg.sv */
// bir_pkg: shared constants and types of the bilinear image resizer
`timescale 1ns / 1ps

package bir_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

	localparam int CFG_W   = 10;
	localparam int COORD_W = 9;
	localparam int PIX_W   = 8;
	localparam int FRAC_W  = 8;

	localparam int SZ_W   = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (CFG_W > SZ_W) ? CFG_W : SZ_W;
	localparam int DEN_W  = CFG_W;
	localparam int PROD_W = COORD_W + SZ_W;
	localparam int NUM_W  = PROD_W + FRAC_W;
	localparam int INT_W  = NUM_W - FRAC_W;

	localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int BANKS      = 4;

	localparam int BLEND_W = PIX_W + FRAC_W;
	localparam int ACC_W   = BLEND_W + FRAC_W;

	localparam int PADDR_W = 4;
	localparam int DATA_W  = 32;

	localparam logic [CFG_W-1:0]  DIM_RESET = CFG_W'(512);
	localparam logic [FRAC_W:0]   W_ONE     = (FRAC_W + 1)'(1) << FRAC_W;
	localparam logic [ACC_W:0]    ROUND_ADD = (ACC_W + 1)'(1) << (2 * FRAC_W - 1);
	localparam logic [PIX_W-1:0]  PIX_MAX   = '1;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} reg_t;

	typedef struct packed {
		action_t             action;
		logic [COORD_W-1:0]  column;
		logic [COORD_W-1:0]  row;
		logic [PIX_W-1:0]    pixel_in;
	} item_t;

	typedef struct packed {
		logic [SZ_W-1:0]  sw;
		logic [SZ_W-1:0]  sh;
		logic [DEN_W-1:0] tw;
		logic [DEN_W-1:0] th;
	} dims_t;

endpackage

/* design/bir_in_if.sv */
// bir_in_if: request channel carrying pixel writes and queries
`timescale 1ns / 1ps

interface bir_in_if;
	import bir_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [COORD_W-1:0]  column;
	logic [COORD_W-1:0]  row;
	logic [PIX_W-1:0]    pixel_in;

	modport source (output valid, action, column, row, pixel_in, input ready);
	modport sink (input valid, action, column, row, pixel_in, output ready);
endinterface

/* design/bir_out_if.sv */
// bir_out_if: response channel carrying interpolated pixels
`timescale 1ns / 1ps

interface bir_out_if;
	import bir_pkg::*;

	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel_out;

	modport source (output valid, pixel_out, input ready);
	modport sink (input valid, pixel_out, output ready);
endinterface

/* design/bir_map.sv */
// bir_map: coordinate scaling multiply and pipelined restoring divider for x and y
`timescale 1ns / 1ps

module bir_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  bir_pkg::item_t              in_item,
	input  bir_pkg::dims_t              dims,
	output logic                        out_valid,
	output bir_pkg::item_t              out_item,
	output logic [bir_pkg::NUM_W-1:0]   qx,
	output logic [bir_pkg::NUM_W-1:0]   qy
);
	import bir_pkg::*;

	logic [PROD_W-1:0] xprod;
	logic [PROD_W-1:0] yprod;

	logic              v_s    [NUM_W+1];
	item_t             item_s [NUM_W+1];
	logic [NUM_W-1:0]  xnum_s [NUM_W];
	logic [NUM_W-1:0]  ynum_s [NUM_W];
	logic [DEN_W-1:0]  xrem_s [NUM_W];
	logic [DEN_W-1:0]  yrem_s [NUM_W];
	logic [NUM_W-1:0]  xquo_s [NUM_W+1];
	logic [NUM_W-1:0]  yquo_s [NUM_W+1];

	assign xprod = PROD_W'(in_item.column) * PROD_W'(dims.sw);
	assign yprod = PROD_W'(in_item.row) * PROD_W'(dims.sh);

	// stage 0: scaled numerators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_item;
			xnum_s[0] <= {xprod, {FRAC_W{1'b0}}};
			ynum_s[0] <= {yprod, {FRAC_W{1'b0}}};
			xrem_s[0] <= '0;
			yrem_s[0] <= '0;
			xquo_s[0] <= '0;
			yquo_s[0] <= '0;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DEN_W:0] xsh;
		logic [DEN_W:0] ysh;
		logic           xge;
		logic           yge;

		always_comb begin
			xsh = {xrem_s[k], xnum_s[k][NUM_W-1]};
			ysh = {yrem_s[k], ynum_s[k][NUM_W-1]};
			xge = xsh >= {1'b0, dims.tw};
			yge = ysh >= {1'b0, dims.th};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k+1] <= item_s[k];
				xquo_s[k+1] <= {xquo_s[k][NUM_W-2:0], xge};
				yquo_s[k+1] <= {yquo_s[k][NUM_W-2:0], yge};
			end
		end

		if (k < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					xnum_s[k+1] <= xnum_s[k] << 1;
					ynum_s[k+1] <= ynum_s[k] << 1;
					xrem_s[k+1] <= xge ? DEN_W'(xsh - {1'b0, dims.tw}) : DEN_W'(xsh);
					yrem_s[k+1] <= yge ? DEN_W'(ysh - {1'b0, dims.th}) : DEN_W'(ysh);
				end
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign out_item  = item_s[NUM_W];
	assign qx        = xquo_s[NUM_W];
	assign qy        = yquo_s[NUM_W];

endmodule

/* design/bilinear_image_resize.sv */
// bilinear_image_resize: top level with register port, banked image store and blend pipeline
//
// request carries words of two kinds: a write stores pixel_in at (column, row) of the
// source image, a query asks for the destination pixel at (column, row). Only queries
// give a response word, carrying the interpolated pixel_out, in request order.
// The four size registers sit on the APB port at byte addresses 0, 4, 8 and 12; write
// them only while no word is in flight. All four reset to 512.
// One word is taken every clock while the skid word is empty. The source image lives in
// four single-port-read banks split by row and column parity, so the four neighbours of a
// query are read in the same cycle; the x and y scale divisions run in a restoring divider
// of NUM_W stages (27 at the default sizes), one quotient bit per stage.
// A query passes the map stages, the bank read, both blends and the output register in turn.
// Writes travel the same pipeline, so a query sees every write accepted before it.
// Reset clears the pipeline and reloads the size registers; the image store is not cleared,
// and a pixel must be written before any query reads it.
// When the receiver stalls, one result waits in the output register and one more in
// a skid word; with both full, request.ready drops and the whole pipeline holds.
`timescale 1ns / 1ps

module bilinear_image_resize (
	input  logic                          clk,
	input  logic                          arst_n,
	bir_in_if.sink                        request,
	bir_out_if.source                     response,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bir_pkg::PADDR_W-1:0]   paddr,
	input  logic [bir_pkg::DATA_W-1:0]    pwdata,
	output logic [bir_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import bir_pkg::*;

	function automatic logic [SZ_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
		logic [SZ_W-1:0] r;
		if (v == '0) begin
			r = SZ_W'(1);
		end else if (CMP_W'(v) > CMP_W'(hi)) begin
			r = SZ_W'(hi);
		end else begin
			r = SZ_W'(v);
		end
		return r;
	endfunction

	// configuration registers
	logic [CFG_W-1:0] src_w_q;
	logic [CFG_W-1:0] src_h_q;
	logic [CFG_W-1:0] dst_w_q;
	logic [CFG_W-1:0] dst_h_q;
	reg_t             reg_sel;

	assign reg_sel = reg_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_RESET;
			src_h_q <= DIM_RESET;
			dst_w_q <= DIM_RESET;
			dst_h_q <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_SRC_W: src_w_q <= pwdata[CFG_W-1:0];
				REG_SRC_H: src_h_q <= pwdata[CFG_W-1:0];
				REG_DST_W: dst_w_q <= pwdata[CFG_W-1:0];
				REG_DST_H: dst_h_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SRC_W: prdata = DATA_W'(src_w_q);
			REG_SRC_H: prdata = DATA_W'(src_h_q);
			REG_DST_W: prdata = DATA_W'(dst_w_q);
			REG_DST_H: prdata = DATA_W'(dst_h_q);
			default:   prdata = '0;
		endcase
	end

	dims_t           dims;
	logic [SZ_W-1:0] sw_m1;
	logic [SZ_W-1:0] sh_m1;

	always_comb begin
		dims.sw = clamp_dim(src_w_q, MAX_WIDTH);
		dims.sh = clamp_dim(src_h_q, MAX_HEIGHT);
		dims.tw = (dst_w_q == '0) ? DEN_W'(1) : dst_w_q;
		dims.th = (dst_h_q == '0) ? DEN_W'(1) : dst_h_q;
		sw_m1   = dims.sw - SZ_W'(1);
		sh_m1   = dims.sh - SZ_W'(1);
	end

	// pipeline advance and output skid
	logic             en;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             skid_valid_q;
	logic [PIX_W-1:0] skid_pix_q;

	assign en            = !skid_valid_q;
	assign request.ready = en;

	item_t in_item;

	always_comb begin
		in_item.action   = action_t'(request.action);
		in_item.column   = request.column;
		in_item.row      = request.row;
		in_item.pixel_in = request.pixel_in;
	end

	logic             map_valid;
	item_t            map_item;
	logic [NUM_W-1:0] qx;
	logic [NUM_W-1:0] qy;

	bir_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (request.valid),
		.in_item   (in_item),
		.dims      (dims),
		.out_valid (map_valid),
		.out_item  (map_item),
		.qx        (qx),
		.qy        (qy)
	);

	// neighbour coordinates and bank addresses
	logic [INT_W-1:0]   ix;
	logic [INT_W-1:0]   iy;
	logic [INT_W-1:0]   swm;
	logic [INT_W-1:0]   shm;
	logic [XW-1:0]      col_l;
	logic [XW-1:0]      col_r;
	logic [YW-1:0]      row_t;
	logic [YW-1:0]      row_b;
	logic [XW-1:0]      col_sel [2];
	logic [YW-1:0]      row_sel [2];
	logic [BANK_AW-1:0] raddr   [BANKS];
	logic [XW-1:0]      wcol;
	logic [YW-1:0]      wrow;
	logic               w_ok;

	always_comb begin
		ix    = qx[NUM_W-1:FRAC_W];
		iy    = qy[NUM_W-1:FRAC_W];
		swm   = INT_W'(sw_m1);
		shm   = INT_W'(sh_m1);
		col_l = (ix > swm) ? XW'(swm) : XW'(ix);
		col_r = (ix >= swm) ? XW'(swm) : XW'(ix + INT_W'(1));
		row_t = (iy > shm) ? YW'(shm) : YW'(iy);
		row_b = (iy >= shm) ? YW'(shm) : YW'(iy + INT_W'(1));
		for (int p = 0; p < 2; p++) begin
			col_sel[p] = (col_l[0] == p[0]) ? col_l : col_r;
			row_sel[p] = (row_t[0] == p[0]) ? row_t : row_b;
		end
		for (int k = 0; k < BANKS; k++) begin
			raddr[k] = BANK_AW'((32'(row_sel[k / 2]) >> 1) * HALF_W
				+ (32'(col_sel[k % 2]) >> 1));
		end
		wcol = XW'(map_item.column);
		wrow = YW'(map_item.row);
		w_ok = (32'(map_item.column) < MAX_WIDTH) && (32'(map_item.row) < MAX_HEIGHT);
	end

	logic               qv_s1;
	logic               we_s1;
	logic [BANK_AW-1:0] raddr_s1 [BANKS];
	logic [BANK_AW-1:0] waddr_s1;
	logic [1:0]         wbank_s1;
	logic [PIX_W-1:0]   wdata_s1;
	logic [XW-1:0]      col_l_s1;
	logic [XW-1:0]      col_r_s1;
	logic               t0_s1;
	logic               b0_s1;
	logic [FRAC_W-1:0]  fx_s1;
	logic [FRAC_W-1:0]  fy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
			we_s1 <= 1'b0;
		end else if (en) begin
			qv_s1 <= map_valid && (map_item.action == ACT_QUERY);
			we_s1 <= map_valid && (map_item.action == ACT_WRITE) && w_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raddr_s1 <= raddr;
			waddr_s1 <= BANK_AW'((32'(wrow) >> 1) * HALF_W + (32'(wcol) >> 1));
			wbank_s1 <= {wrow[0], wcol[0]};
			wdata_s1 <= map_item.pixel_in;
			col_l_s1 <= col_l;
			col_r_s1 <= col_r;
			t0_s1    <= row_t[0];
			b0_s1    <= row_b[0];
			fx_s1    <= qx[FRAC_W-1:0];
			fy_s1    <= qy[FRAC_W-1:0];
		end
	end

	// image store: four banks by row and column parity
	logic [PIX_W-1:0] rd_s2 [BANKS];

	for (genvar k = 0; k < BANKS; k++) begin : g_bank
		logic [PIX_W-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (en) begin
				if (we_s1 && (wbank_s1 == 2'(k))) begin
					mem[waddr_s1] <= wdata_s1;
				end
				rd_s2[k] <= mem[raddr_s1[k]];
			end
		end
	end

	logic              qv_s2;
	logic              l0_s2;
	logic              r0_s2;
	logic              t0_s2;
	logic              b0_s2;
	logic [FRAC_W-1:0] fx_s2;
	logic [FRAC_W-1:0] fy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s2 <= 1'b0;
		end else if (en) begin
			qv_s2 <= qv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l0_s2 <= col_l_s1[0];
			r0_s2 <= col_r_s1[0];
			t0_s2 <= t0_s1;
			b0_s2 <= b0_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
		end
	end

	// horizontal blend
	logic [PIX_W-1:0] p_lt;
	logic [PIX_W-1:0] p_rt;
	logic [PIX_W-1:0] p_lb;
	logic [PIX_W-1:0] p_rb;
	logic [FRAC_W:0]  wx_inv;

	always_comb begin
		p_lt   = rd_s2[{t0_s2, l0_s2}];
		p_rt   = rd_s2[{t0_s2, r0_s2}];
		p_lb   = rd_s2[{b0_s2, l0_s2}];
		p_rb   = rd_s2[{b0_s2, r0_s2}];
		wx_inv = W_ONE - (FRAC_W + 1)'(fx_s2);
	end

	logic               qv_s3;
	logic [BLEND_W-1:0] top_s3;
	logic [BLEND_W-1:0] bot_s3;
	logic [FRAC_W-1:0]  fy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s3 <= 1'b0;
		end else if (en) begin
			qv_s3 <= qv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s3 <= BLEND_W'(p_rt) * BLEND_W'(fx_s2) + BLEND_W'(p_lt) * BLEND_W'(wx_inv);
			bot_s3 <= BLEND_W'(p_rb) * BLEND_W'(fx_s2) + BLEND_W'(p_lb) * BLEND_W'(wx_inv);
			fy_s3  <= fy_s2;
		end
	end

	// vertical blend
	logic [FRAC_W:0] wy_inv;

	assign wy_inv = W_ONE - (FRAC_W + 1)'(fy_s3);

	logic             qv_s4;
	logic [ACC_W-1:0] acc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s4 <= 1'b0;
		end else if (en) begin
			qv_s4 <= qv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s4 <= ACC_W'(top_s3) * ACC_W'(wy_inv) + ACC_W'(bot_s3) * ACC_W'(fy_s3);
		end
	end

	// round half up and saturate
	logic [ACC_W:0]               rsum;
	logic [ACC_W-2*FRAC_W:0]      rfull;
	logic [PIX_W-1:0]             res;
	logic                         push;
	logic                         pop;

	always_comb begin
		rsum  = (ACC_W + 1)'(acc_s4) + ROUND_ADD;
		rfull = rsum[ACC_W:2*FRAC_W];
		res   = (rfull > (ACC_W - 2 * FRAC_W + 1)'(PIX_MAX)) ? PIX_MAX : PIX_W'(rfull);
		push  = en && qv_s4;
		pop   = out_valid_q && response.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_pix_q <= skid_pix_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_pix_q <= res;
			end else begin
				out_pix_q <= res;
			end
		end
	end

	assign response.valid     = out_valid_q;
	assign response.pixel_out = out_pix_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without a word in the output register");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("finished query result was dropped");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(qv_s4) && $stable(qv_s1) && (!qv_s4 || $stable(acc_s4)))
		else $error("pipeline moved while stalled");

	a_neighbours: assert property (@(posedge clk) disable iff (!arst_n)
		qv_s1 |-> (SZ_W'(col_r_s1) <= sw_m1) && (col_l_s1 <= col_r_s1)
			&& (col_r_s1 - col_l_s1 <= XW'(1)))
		else $error("neighbour columns outside the source image");

	a_no_write_and_query: assert property (@(posedge clk) disable iff (!arst_n)
		we_s1 |-> !qv_s1 && !$past(skid_valid_q && !pop && push))
		else $error("store write overlaps a query slot");

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench of the bilinear image resizer with a scoreboard of blended pixels
`timescale 1ns / 1ps

module testbench;
	import bir_pkg::*;

	localparam int LATENCY = NUM_W + 5;
	localparam int STORE   = MAX_WIDTH * MAX_HEIGHT;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	bir_in_if  request_ch();
	bir_out_if response_ch();

	bilinear_image_resize u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	item_t            request_queue [$];
	logic [PIX_W-1:0] expected_pixels [$];
	bit [PIX_W-1:0]   image_mirror [STORE];
	bit               written_map [STORE];
	logic [CFG_W-1:0] size_reg [4];
	int               fail_count;
	int               words_made;
	bit               calm;
	int               gap_cycles;
	int               stall_cycles;
	item_t            next_word;
	logic [PIX_W-1:0] want_pixel;

	logic [CFG_W-1:0] corner_sizes [7][4] = '{
		'{10'd1, 10'd1, 10'd1, 10'd1},
		'{10'd0, 10'd0, 10'd0, 10'd0},
		'{10'd1023, 10'd1023, 10'd1023, 10'd1023},
		'{10'd512, 10'd512, 10'd1, 10'd1},
		'{10'd3, 10'd5, 10'd512, 10'd512},
		'{10'd512, 10'd1, 10'd7, 10'd512},
		'{10'd1, 10'd512, 10'd512, 10'd3}
	};

	function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned top);
		return (v == '0) ? 1 : (32'(v) > top) ? top : 32'(v);
	endfunction

	// source neighbours and 8-bit weights of a destination coordinate
	function automatic void tap_points(input logic [COORD_W-1:0] col, row,
			output int unsigned lx, rx, ty, by, fx, fy);
		int unsigned      sw, sh, tw, th;
		longint unsigned  px, py;
		sw = span(size_reg[REG_SRC_W], MAX_WIDTH);
		sh = span(size_reg[REG_SRC_H], MAX_HEIGHT);
		tw = (size_reg[REG_DST_W] == '0) ? 1 : 32'(size_reg[REG_DST_W]);
		th = (size_reg[REG_DST_H] == '0) ? 1 : 32'(size_reg[REG_DST_H]);
		px = 64'(col) * 64'(sw) * 256 / 64'(tw);
		py = 64'(row) * 64'(sh) * 256 / 64'(th);
		fx = 32'(px[7:0]);
		fy = 32'(py[7:0]);
		lx = ((px >> 8) >= 64'(sw)) ? sw - 1 : 32'(px >> 8);
		ty = ((py >> 8) >= 64'(sh)) ? sh - 1 : 32'(py >> 8);
		rx = ((px >> 8) + 1 >= 64'(sw)) ? sw - 1 : 32'((px >> 8) + 1);
		by = ((py >> 8) + 1 >= 64'(sh)) ? sh - 1 : 32'((py >> 8) + 1);
	endfunction

	function automatic logic [PIX_W-1:0] blend_pixel(logic [COORD_W-1:0] col, row);
		int unsigned      lx, rx, ty, by, fx, fy;
		longint unsigned  upper, lower, acc;
		tap_points(col, row, lx, rx, ty, by, fx, fy);
		upper = 64'(image_mirror[ty * MAX_WIDTH + rx]) * fx
			+ 64'(image_mirror[ty * MAX_WIDTH + lx]) * (256 - fx);
		lower = 64'(image_mirror[by * MAX_WIDTH + rx]) * fx
			+ 64'(image_mirror[by * MAX_WIDTH + lx]) * (256 - fx);
		acc = (upper * (256 - fy) + lower * fy + 32768) >> 16;
		if (acc > 255)
			acc = 255;
		return acc[PIX_W-1:0];
	endfunction

	function automatic void take_request(item_t w);
		if (w.action == ACT_WRITE)
			image_mirror[int'(w.row) * MAX_WIDTH + int'(w.column)] = w.pixel_in;
		else
			expected_pixels.push_back(blend_pixel(w.column, w.row));
	endfunction

	function automatic void queue_write(logic [COORD_W-1:0] col, row, logic [PIX_W-1:0] pix);
		request_queue.push_back(item_t'{ACT_WRITE, col, row, pix});
		written_map[int'(row) * MAX_WIDTH + int'(col)] = 1'b1;
		words_made++;
	endfunction

	// fill any unwritten neighbour first so that no query reads an empty entry
	function automatic void queue_query(logic [COORD_W-1:0] col, row);
		int unsigned lx, rx, ty, by, fx, fy, cx, cy;
		tap_points(col, row, lx, rx, ty, by, fx, fy);
		for (int k = 0; k < 4; k++) begin
			cx = k[0] ? rx : lx;
			cy = k[1] ? by : ty;
			if (!written_map[cy * MAX_WIDTH + cx])
				queue_write(COORD_W'(cx), COORD_W'(cy), PIX_W'($urandom));
		end
		request_queue.push_back(item_t'{ACT_QUERY, col, row, PIX_W'($urandom)});
		words_made++;
	endfunction

	function automatic void random_batch(int count);
		int unsigned sw, sh, qw, qh;
		int          stop;
		sw   = span(size_reg[REG_SRC_W], MAX_WIDTH);
		sh   = span(size_reg[REG_SRC_H], MAX_HEIGHT);
		qw   = span(size_reg[REG_DST_W], MAX_WIDTH);
		qh   = span(size_reg[REG_DST_H], MAX_HEIGHT);
		stop = words_made + count;
		while (words_made < stop) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 4) != 0)
					queue_write(COORD_W'($urandom_range(0, sw - 1)),
						COORD_W'($urandom_range(0, sh - 1)), PIX_W'($urandom));
				else
					queue_write(COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
			end else if ($urandom_range(0, 6) != 0) begin
				queue_query(COORD_W'($urandom_range(0, qw - 1)),
					COORD_W'($urandom_range(0, qh - 1)));
			end else begin
				queue_query(COORD_W'($urandom), COORD_W'($urandom));
			end
		end
	endfunction

	function automatic logic [CFG_W-1:0] pick_source();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(512);
			2: return CFG_W'($urandom_range(513, 1023));
			3: return CFG_W'($urandom_range(1, 512));
			default: return CFG_W'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_target();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'($urandom_range(513, 1023));
			2, 3: return CFG_W'($urandom_range(25, 512));
			default: return CFG_W'($urandom_range(1, 24));
		endcase
	endfunction

	task automatic write_register(reg_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(int'(idx) * 4);
		pwdata  <= {(DATA_W - CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		size_reg[idx] = value;
	endtask

	task automatic set_sizes(logic [CFG_W-1:0] sw, sh, tw, th);
		write_register(REG_SRC_W, sw);
		write_register(REG_SRC_H, sh);
		write_register(REG_DST_W, tw);
		write_register(REG_DST_H, th);
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (request_queue.size() != 0 || request_ch.valid || expected_pixels.size() != 0);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_ch.valid    <= 1'b0;
			request_ch.action   <= ACT_WRITE;
			request_ch.column   <= '0;
			request_ch.row      <= '0;
			request_ch.pixel_in <= '0;
			gap_cycles          <= 0;
		end else begin
			if (request_ch.valid && request_ch.ready)
				take_request(item_t'{action_t'(request_ch.action), request_ch.column,
					request_ch.row, request_ch.pixel_in});
			if (!request_ch.valid || request_ch.ready) begin
				if (gap_cycles != 0) begin
					gap_cycles       <= gap_cycles - 1;
					request_ch.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_word = request_queue.pop_front();
					request_ch.valid    <= 1'b1;
					request_ch.action   <= next_word.action;
					request_ch.column   <= next_word.column;
					request_ch.row      <= next_word.row;
					request_ch.pixel_in <= next_word.pixel_in;
					if (!calm && $urandom_range(0, 5) == 0)
						gap_cycles <= $urandom_range(1, 12);
				end else begin
					request_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_ch.ready <= 1'b0;
			stall_cycles      <= 0;
		end else begin
			if (response_ch.valid && response_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel_out expected none actual %0d", response_ch.pixel_out);
					fail_count++;
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (response_ch.pixel_out !== want_pixel) begin
						$error("pixel_out expected %0d actual %0d", want_pixel,
							response_ch.pixel_out);
						fail_count++;
					end
				end
			end
			if (stall_cycles != 0) begin
				stall_cycles      <= stall_cycles - 1;
				response_ch.ready <= 1'b0;
			end else begin
				response_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 11) == 0)
					stall_cycles <= $urandom_range(1, 12);
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		calm                = 1'b0;
		fail_count          = 0;
		words_made          = 0;
		for (int i = 0; i < 4; i++)
			size_reg[i] = DIM_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners, center and pixel extremes at the reset sizes
		queue_write(9'd0, 9'd0, 8'h00);
		queue_write(9'd511, 9'd0, 8'hFF);
		queue_write(9'd0, 9'd511, 8'hFF);
		queue_write(9'd511, 9'd511, 8'h00);
		queue_write(9'd256, 9'd255, 8'hAA);
		queue_write(9'd257, 9'd255, 8'h55);
		queue_query(9'd0, 9'd0);
		queue_query(9'd511, 9'd0);
		queue_query(9'd0, 9'd511);
		queue_query(9'd511, 9'd511);
		queue_query(9'd256, 9'd255);
		queue_query(9'd255, 9'd256);
		drain();

		for (int p = 0; p < 7; p++) begin
			set_sizes(corner_sizes[p][0], corner_sizes[p][1], corner_sizes[p][2],
				corner_sizes[p][3]);
			queue_query(9'd0, 9'd0);
			queue_query(9'd511, 9'd511);
			random_batch(60);
			drain();
		end

		while (words_made < 1800) begin
			set_sizes(pick_source(), pick_source(), pick_target(), pick_target());
			calm = ($urandom_range(0, 3) == 0);
			random_batch($urandom_range(80, 200));
			drain();
		end

		set_sizes(pick_source(), pick_source(), pick_target(), pick_target());
		calm = 1'b1;
		random_batch(100);
		drain();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
